FILE: hw/rtl/pedometer_step_counter_macros.svh
// ----------------------------------------------------------------------------
// Pedometer step counter assertion macros
// Concurrent check wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef PEDOMETER_STEP_COUNTER_MACROS_SVH
`define PEDOMETER_STEP_COUNTER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PSC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pedometer implication check failed");
// next-cycle implication
`define PSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pedometer next-cycle check failed");
`else
`define PSC_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define PSC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/pedo_pkg.sv
// ----------------------------------------------------------------------------
// Pedometer package
// Shared types, field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package pedo_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILT,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   // per-cycle command to the cell row
   typedef struct packed {
      logic shift;
      logic scan;
   } cell_ctrl_type;

   localparam int THR_W      = 18;
   localparam int STEP_W     = 16;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam int PREC_W     = 17;
   localparam int REG_CNT_W  = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_PRECISION = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INT   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INT   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_REG_COUNT = CSR_IDX_W'(3);

   localparam logic [PREC_W-1:0]     PREC_RESET    = PREC_W'(100);
   localparam logic [INTERVAL_W-1:0] MIN_INT_RESET = INTERVAL_W'(200);
   localparam logic [INTERVAL_W-1:0] MAX_INT_RESET = INTERVAL_W'(2000);
   localparam logic [REG_CNT_W-1:0]  REG_CNT_RESET = REG_CNT_W'(4);

   localparam logic [STEP_W-1:0] STEP_MAX = '1;

endpackage

`default_nettype wire

FILE: hw/rtl/pedo_if.sv
// ----------------------------------------------------------------------------
// Pedometer channels
// Sample request, step result and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface pedo_req_if #(parameter int AXIS_BITS = 16);
   logic                        valid;
   logic                        ready;
   logic signed [AXIS_BITS-1:0] accel_x;
   logic signed [AXIS_BITS-1:0] accel_y;
   logic signed [AXIS_BITS-1:0] accel_z;
   logic [pedo_pkg::TIME_W-1:0] stamp_ms;

   modport source (output valid, accel_x, accel_y, accel_z, stamp_ms, input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, stamp_ms, output ready);
endinterface

interface pedo_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [pedo_pkg::STEP_W-1:0]        steps_counted;
   logic                               walking_confirmed;
   logic                               step_detected;
   logic                               regulation_reset;
   logic signed [pedo_pkg::THR_W-1:0]  current_threshold;

   modport source (output valid, steps_counted, walking_confirmed, step_detected,
                   regulation_reset, current_threshold, input ready);
   modport sink   (input valid, steps_counted, walking_confirmed, step_detected,
                   regulation_reset, current_threshold, output ready);
endinterface

interface pedo_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pedo_pkg::CSR_IDX_W-1:0]  index;
   logic [pedo_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pedo_cell.sv
// ----------------------------------------------------------------------------
// Pedometer window cell
// Holds one window sample and folds it into the passing min/max wave.
// ----------------------------------------------------------------------------
`default_nettype none

module pedo_cell #(
   parameter int WIDTH  = 18,
   parameter int INDEX  = 0,
   parameter int FILL_W = 6
) (
   input  logic                    clock,
   input  pedo_pkg::cell_ctrl_type ctrl,
   input  logic signed [WIDTH-1:0] data_in,
   input  logic [FILL_W-1:0]       fill_count,
   input  logic signed [WIDTH-1:0] lo_in,
   input  logic signed [WIDTH-1:0] hi_in,
   output logic signed [WIDTH-1:0] data_out,
   output logic signed [WIDTH-1:0] lo_out,
   output logic signed [WIDTH-1:0] hi_out
);

   logic signed [WIDTH-1:0] data_ff, lo_ff, hi_ff;
   logic signed [WIDTH-1:0] lo_in_w, hi_in_w;
   logic                    filled;

   // only entries already written take part
   assign filled = fill_count > FILL_W'(INDEX);

   always_comb begin
      lo_in_w = lo_in;
      hi_in_w = hi_in;
      if (filled && data_ff < lo_in) begin
         lo_in_w = data_ff;
      end
      if (filled && data_ff > hi_in) begin
         hi_in_w = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         data_ff <= data_in;
      end
      if (ctrl.scan) begin
         lo_ff <= lo_in_w;
         hi_ff <= hi_in_w;
      end
   end

   assign data_out = data_ff;
   assign lo_out   = lo_ff;
   assign hi_out   = hi_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/pedo_chain.sv
// ----------------------------------------------------------------------------
// Pedometer window row
// Shift row of sample cells with fill count and min/max wave sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module pedo_chain #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 50
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pedo_pkg::cell_ctrl_type ctrl,
   input  logic signed [WIDTH-1:0] data_in,
   input  logic signed [WIDTH-1:0] seed,
   output logic signed [WIDTH-1:0] lo_out,
   output logic signed [WIDTH-1:0] hi_out,
   output logic                    scan_done
);

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int SCAN_W = $clog2(DEPTH);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [SCAN_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic              scan_last;

   logic signed [WIDTH-1:0] data_link [DEPTH];
   logic signed [WIDTH-1:0] lo_link   [DEPTH];
   logic signed [WIDTH-1:0] hi_link   [DEPTH];

   assign scan_last = scan_cnt_ff == SCAN_W'(DEPTH - 1);
   assign scan_done = ctrl.scan && scan_last;

   always_comb begin
      fill_in     = fill_ff;
      scan_cnt_in = scan_cnt_ff;
      if (ctrl.shift && fill_ff < FILL_W'(DEPTH)) begin
         fill_in = fill_ff + FILL_W'(1);
      end
      if (ctrl.scan) begin
         scan_cnt_in = scan_last ? '0 : scan_cnt_ff + SCAN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         scan_cnt_ff <= '0;
      end else begin
         fill_ff     <= fill_in;
         scan_cnt_ff <= scan_cnt_in;
      end
   end

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic signed [WIDTH-1:0] d_src, lo_src, hi_src;
      if (k == 0) begin : g_head
         assign d_src  = data_in;
         assign lo_src = seed;
         assign hi_src = seed;
      end else begin : g_body
         assign d_src  = data_link[k-1];
         assign lo_src = lo_link[k-1];
         assign hi_src = hi_link[k-1];
      end
      pedo_cell #(
         .WIDTH  (WIDTH),
         .INDEX  (k),
         .FILL_W (FILL_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .data_in    (d_src),
         .fill_count (fill_ff),
         .lo_in      (lo_src),
         .hi_in      (hi_src),
         .data_out   (data_link[k]),
         .lo_out     (lo_link[k]),
         .hi_out     (hi_link[k])
      );
   end

   assign lo_out = lo_link[DEPTH-1];
   assign hi_out = hi_link[DEPTH-1];

endmodule

`default_nettype wire

FILE: hw/rtl/pedometer_step_counter.sv
// ----------------------------------------------------------------------------
// Pedometer step counter with dynamic threshold
// Sequence: each accepted sample is filtered into the head cell, then the min/max
// wave scans the row and the result register loads; no new sample is taken before.
//   The load waits while an earlier result waits on rsp ready.
// Reset: synchronous, active high; only control and config registers reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pedometer_step_counter_macros.svh"

module pedometer_step_counter #(
   parameter int WINDOW_DEPTH = 50,
   parameter int AXIS_BITS    = 16
) (
   input  logic       clock,
   input  logic       reset,
   pedo_req_if.sink   req_bus,
   pedo_rsp_if.source rsp_bus,
   pedo_csr_if.sink   csr_bus
);

   // three axes summed need two extra bits
   localparam int SUM_W  = AXIS_BITS + 2;
   localparam int DIFF_W = SUM_W + 1;
   localparam int CMP_W  = (DIFF_W > pedo_pkg::PREC_W) ? DIFF_W : pedo_pkg::PREC_W;
   localparam int EXT_W  = (SUM_W > pedo_pkg::THR_W) ? SUM_W : pedo_pkg::THR_W;

   // --- configuration registers ---
   logic [pedo_pkg::PREC_W-1:0]     precision_ff;
   logic [pedo_pkg::INTERVAL_W-1:0] min_int_ff;
   logic [pedo_pkg::INTERVAL_W-1:0] max_int_ff;
   logic [pedo_pkg::REG_CNT_W-1:0]  reg_count_ff;

   // write channel never stalls
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         precision_ff <= pedo_pkg::PREC_RESET;
         min_int_ff   <= pedo_pkg::MIN_INT_RESET;
         max_int_ff   <= pedo_pkg::MAX_INT_RESET;
         reg_count_ff <= pedo_pkg::REG_CNT_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            pedo_pkg::CSR_PRECISION: precision_ff <= csr_bus.data[pedo_pkg::PREC_W-1:0];
            pedo_pkg::CSR_MIN_INT:   min_int_ff   <= csr_bus.data[pedo_pkg::INTERVAL_W-1:0];
            pedo_pkg::CSR_MAX_INT:   max_int_ff   <= csr_bus.data[pedo_pkg::INTERVAL_W-1:0];
            pedo_pkg::CSR_REG_COUNT: reg_count_ff <= csr_bus.data[pedo_pkg::REG_CNT_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // --- sequencer and state ---
   pedo_pkg::state_type     state_ff, state_in;
   pedo_pkg::cell_ctrl_type cell_ctrl;

   logic signed [SUM_W-1:0]        sum_ff, sum_in;       // captured axis sum
   logic [pedo_pkg::TIME_W-1:0]    time_ff;
   logic signed [SUM_W-1:0]        last_filt_ff, last_filt_in;
   logic signed [SUM_W-1:0]        prev_ff;              // filtered value before update
   logic [pedo_pkg::STEP_W-1:0]    step_total_ff, step_total_in;
   logic [pedo_pkg::TIME_W-1:0]    last_step_ff, last_step_in;
   logic                           mode_ff, mode_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pedo_pkg::STEP_W-1:0]    rsp_steps_ff;
   logic                           rsp_mode_ff;
   logic                           rsp_detect_ff;
   logic                           rsp_clear_ff;
   logic signed [pedo_pkg::THR_W-1:0] rsp_thr_ff;

   logic req_accept, rsp_load;

   // filter datapath
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        abs_diff;
   logic signed [SUM_W-1:0]  cur;

   // window row
   logic signed [SUM_W-1:0]  win_lo, win_hi;
   logic                     scan_done;

   // decision datapath
   logic signed [SUM_W:0]         mid_sum;
   logic signed [SUM_W-1:0]       thr;
   logic signed [EXT_W-1:0]       thr_ext;
   logic [pedo_pkg::TIME_W-1:0]   interval;
   logic                          in_window, step_seen, counted, cleared;
   logic [pedo_pkg::STEP_W-1:0]   total_next;
   logic                          mode_next;

   assign req_bus.ready = state_ff == pedo_pkg::ST_IDLE;
   assign req_accept    = req_bus.valid && req_bus.ready;

   // axis sum taken straight off the request
   assign sum_in = SUM_W'(req_bus.accel_x) + SUM_W'(req_bus.accel_y)
                 + SUM_W'(req_bus.accel_z);

   // dead band: keep the old value unless the change exceeds the precision
   assign diff     = DIFF_W'(last_filt_ff) - DIFF_W'(sum_ff);
   assign abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign cur      = (CMP_W'(abs_diff) > CMP_W'(precision_ff)) ? sum_ff : last_filt_ff;

   // floor((min + max) / 2), the arithmetic shift rounds toward minus infinity
   assign mid_sum = (SUM_W+1)'(win_lo) + (SUM_W+1)'(win_hi);
   assign thr     = $signed(mid_sum[SUM_W:1]);
   assign thr_ext = EXT_W'(thr);

   // interval wraps modulo 2^32
   assign interval  = time_ff - last_step_ff;
   assign in_window = interval > pedo_pkg::TIME_W'(min_int_ff)
                   && interval < pedo_pkg::TIME_W'(max_int_ff);
   assign step_seen = last_filt_ff < prev_ff && last_filt_ff < thr;
   assign counted   = step_seen && (step_total_ff == '0 || in_window);
   assign cleared   = step_seen && !counted;

   always_comb begin
      total_next = step_total_ff;
      mode_next  = mode_ff;
      if (counted) begin
         // saturating count, the step still counts at the top
         if (step_total_ff != pedo_pkg::STEP_MAX) begin
            total_next = step_total_ff + pedo_pkg::STEP_W'(1);
         end
         if (total_next >= pedo_pkg::STEP_W'(reg_count_ff)) begin
            mode_next = 1'b1;
         end
      end else if (cleared) begin
         total_next = '0;
         mode_next  = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cell_ctrl     = '0;
      last_filt_in  = last_filt_ff;
      step_total_in = step_total_ff;
      last_step_in  = last_step_ff;
      mode_in       = mode_ff;
      rsp_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      unique case (state_ff)
         pedo_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = pedo_pkg::ST_FILT;
            end
         end
         pedo_pkg::ST_FILT: begin
            // new filtered value enters the head cell
            cell_ctrl.shift = 1'b1;
            last_filt_in    = cur;
            state_in        = pedo_pkg::ST_SCAN;
         end
         pedo_pkg::ST_SCAN: begin
            cell_ctrl.scan = 1'b1;
            if (scan_done) begin
               state_in = pedo_pkg::ST_DECIDE;
            end
         end
         pedo_pkg::ST_DECIDE: begin
            // wait for a free output register before committing
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load      = 1'b1;
               rsp_valid_in  = 1'b1;
               step_total_in = total_next;
               mode_in       = mode_next;
               if (counted) begin
                  last_step_in = time_ff;
               end
               state_in = pedo_pkg::ST_IDLE;
            end
         end
         default: state_in = pedo_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pedo_pkg::ST_IDLE;
         last_filt_ff  <= '0;
         step_total_ff <= '0;
         last_step_ff  <= '0;
         mode_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_filt_ff  <= last_filt_in;
         step_total_ff <= step_total_in;
         last_step_ff  <= last_step_in;
         mode_ff       <= mode_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sum_ff  <= sum_in;
         time_ff <= req_bus.stamp_ms;
      end
      if (cell_ctrl.shift) begin
         prev_ff <= last_filt_ff;
      end
      if (rsp_load) begin
         rsp_steps_ff  <= total_next;
         rsp_mode_ff   <= mode_next;
         rsp_detect_ff <= counted;
         rsp_clear_ff  <= cleared;
         rsp_thr_ff    <= thr_ext[pedo_pkg::THR_W-1:0];
      end
   end

   // window row; the wave is seeded with the newest filtered value
   pedo_chain #(
      .WIDTH (SUM_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (cell_ctrl),
      .data_in   (cur),
      .seed      (last_filt_ff),
      .lo_out    (win_lo),
      .hi_out    (win_hi),
      .scan_done (scan_done)
   );

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.steps_counted     = rsp_steps_ff;
   assign rsp_bus.walking_confirmed = rsp_mode_ff;
   assign rsp_bus.step_detected     = rsp_detect_ff;
   assign rsp_bus.regulation_reset  = rsp_clear_ff;
   assign rsp_bus.current_threshold = rsp_thr_ff;

   // --- checks ---
   `PSC_ASSERT_NEXT(a_accept_filters, clock, reset, req_accept, state_ff == pedo_pkg::ST_FILT)
   `PSC_ASSERT_IMPLY(a_step_nonzero, clock, reset, rsp_valid_ff && rsp_detect_ff, rsp_steps_ff != '0)
   `PSC_ASSERT_IMPLY(a_clear_zeroes, clock, reset, rsp_valid_ff && rsp_clear_ff, rsp_steps_ff == '0 && !rsp_mode_ff && !rsp_detect_ff)
   `PSC_ASSERT_IMPLY(a_done_in_scan, clock, reset, scan_done, state_ff == pedo_pkg::ST_SCAN)

endmodule

`default_nettype wire
